FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int PRI_W   = 3;
    localparam int TAG_W   = 8;
    localparam int OCC_W   = 5;
    localparam int NUM_PRI = 4;

    localparam logic [PRI_W-1:0] PRI_MIN = 3'd1;
    localparam logic [PRI_W-1:0] PRI_MAX = 3'd4;

    typedef enum logic {
        MODE_ENQ = 1'b0,
        MODE_DEQ = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic             mode;
        logic [PRI_W-1:0] priority_req;
        logic [TAG_W-1:0] tag;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [PRI_W-1:0] out_priority;
        logic [TAG_W-1:0] out_tag;
        logic [OCC_W-1:0] occupancy;
    } t_out_word;

    // one slot of the queue
    typedef struct packed {
        logic             valid;
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // broadcast from the control to every cell
    typedef struct packed {
        logic             enq;
        logic             deq;
        logic [PRI_W-1:0] min_pri;
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
    } t_cell_ctl;

    function automatic logic [PRI_W-1:0] clamp_pri(input logic [PRI_W-1:0] p);
        logic [PRI_W-1:0] r;
        r = p;
        if (p < PRI_MIN) begin
            r = PRI_MIN;
        end else if (p > PRI_MAX) begin
            r = PRI_MAX;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: loads on enqueue when it is the first free slot, takes its
// right neighbour's entry on dequeue at and after the removed slot.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spq_pkg::t_cell_ctl                i_ctl,
    input  logic                              i_left_valid,
    input  logic                              i_hit,
    input  spq_pkg::t_entry                   i_right,
    output spq_pkg::t_entry                   o_entry,
    output logic                              o_hit,
    output logic                              o_first,
    output logic [spq_pkg::NUM_PRI-1:0]       o_has_pri
);
    import spq_pkg::*;

    logic             r_valid;
    logic [PRI_W-1:0] r_pri;
    logic [TAG_W-1:0] r_tag;
    logic             w_match;
    logic             w_shift;
    logic             w_load;

    assign w_match = r_valid && (r_pri == i_ctl.min_pri);
    assign o_hit   = i_hit | w_match;
    assign o_first = w_match & ~i_hit;
    assign w_shift = i_ctl.deq & o_hit;
    assign w_load  = i_ctl.enq & ~r_valid & i_left_valid;

    always_comb begin
        for (int j = 0; j < NUM_PRI; j++) begin
            o_has_pri[j] = r_valid && (r_pri == PRI_W'(j + 1));
        end
    end

    assign o_entry.valid = r_valid;
    assign o_entry.pri   = r_pri;
    assign o_entry.tag   = r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_right.valid;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_pri <= i_right.pri;
            r_tag <= i_right.tag;
        end else if (w_load) begin
            r_pri <= i_ctl.pri;
            r_tag <= i_ctl.tag;
        end
    end

endmodule

FILE: hw/rtl/stable_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded queue kept in arrival order in a row of cells; dequeue removes the
// oldest entry of the most urgent priority and closes the gap.
//
//   channel   direction   signals                          word
//   in        input       i_in_valid / o_in_ready          t_in_word
//   out       output      o_out_valid / i_out_ready        t_out_word
//
// each word is accepted in S_IDLE, which registers the lowest held priority
// (or-tree over the cells); S_EXEC then runs the hit chain along the cells,
// shifts or loads them and writes the output register
// synchronous active-low reset empties the queue at once, no clearing pass
// a word is taken while the previous result still waits; a held result
// stalls S_EXEC until it is taken
// ----------------------------------------------------------------------------
module stable_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  spq_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spq_pkg::t_out_word  o_out_word
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state           r_state, n_state;
    t_in_word         r_in;
    logic [PRI_W-1:0] r_min, n_min;
    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid;
    t_out_word        r_out;

    t_cell_ctl        w_ctl;
    t_entry           w_entry [DEPTH+1];
    logic [DEPTH:0]   w_hit;
    logic [DEPTH:0]   w_left;
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_first;
    logic [NUM_PRI-1:0] w_has [DEPTH];
    logic [NUM_PRI-1:0] w_has_any;
    logic [TAG_W-1:0] w_sel_tag;
    logic             w_fire;
    logic             w_is_enq;
    logic             w_full;
    logic             w_empty;
    logic [CW+OCC_W-1:0] w_occ_ext;
    t_out_word        n_out;

    // cell row
    assign w_hit[0]       = 1'b0;
    assign w_left[0]      = 1'b1;
    assign w_entry[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_left_valid (w_left[g]),
            .i_hit        (w_hit[g]),
            .i_right      (w_entry[g+1]),
            .o_entry      (w_entry[g]),
            .o_hit        (w_hit[g+1]),
            .o_first      (w_first[g]),
            .o_has_pri    (w_has[g])
        );
        assign w_valid[g]  = w_entry[g].valid;
        assign w_left[g+1] = w_entry[g].valid;
    end

    // lowest held priority
    always_comb begin
        w_has_any = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_has_any = w_has_any | w_has[i];
        end
        n_min = PRI_MAX;
        for (int j = NUM_PRI - 1; j >= 0; j--) begin
            if (w_has_any[j]) begin
                n_min = PRI_W'(j + 1);
            end
        end
    end

    // tag of the removed slot
    always_comb begin
        w_sel_tag = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel_tag = w_sel_tag | ({TAG_W{w_first[i]}} & w_entry[i].tag);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign w_is_enq   = (r_in.mode == MODE_ENQ);
    assign w_full     = w_valid[DEPTH-1];
    assign w_empty    = ~w_valid[0];

    always_comb begin
        w_ctl.enq     = w_fire & w_is_enq & ~w_full;
        w_ctl.deq     = w_fire & ~w_is_enq & ~w_empty;
        w_ctl.min_pri = r_min;
        w_ctl.pri     = clamp_pri(r_in.priority_req);
        w_ctl.tag     = r_in.tag;
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.enq) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.deq) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_occ_ext = {{OCC_W{1'b0}}, n_count};

    always_comb begin
        n_out.status       = ST_OK;
        n_out.out_priority = '0;
        n_out.out_tag      = '0;
        n_out.occupancy    = w_occ_ext[OCC_W-1:0];
        if (w_is_enq) begin
            if (w_full) begin
                n_out.status = ST_FULL;
            end
        end else if (w_empty) begin
            n_out.status = ST_EMPTY;
        end else begin
            n_out.out_priority = r_min;
            n_out.out_tag      = w_sel_tag;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in  <= i_in_word;
            r_min <= n_min;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // count agrees with the occupied cells
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == 32'($countones(w_valid)))
        else $error("count does not match occupied cells");

    // occupied cells form a contiguous run from the oldest slot
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("gap in occupied cells");

    // at most one slot is picked for removal
    a_one_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("several slots picked");

    // an empty report leaves nothing held
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !w_is_enq && w_empty |=> o_out_word.occupancy == '0)
        else $error("empty report with entries held");

endmodule
